FILE: hdl/sirt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_pkg
// Shared widths, codes, command/status bundles and helper functions for the
// signed integer to radix text converter.
// ----------------------------------------------------------------------------
package sirt_pkg;

   localparam int VALUE_W       = 63;
   localparam int MAG_W         = 64;
   localparam int RADIX_W       = 6;
   localparam int CHAR_W        = 7;
   localparam int DIG_W         = 6;
   localparam int DEPTH         = 64;
   localparam int CNT_W         = $clog2(DEPTH);
   localparam int BITS_PER_STEP = 4;
   localparam int STEPS         = MAG_W / BITS_PER_STEP;
   localparam int STEP_W        = $clog2(STEPS);
   localparam int ADDR_W        = 3;
   localparam int DATA_W        = 32;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd16;
   localparam logic [RADIX_W-1:0] BASE_MIN    = 6'd2;
   localparam logic [RADIX_W-1:0] BASE_MAX    = 6'd36;
   localparam logic [CHAR_W-1:0]  ASCII_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0]  ASCII_A     = 7'h41;

   // register index, taken from paddr bit 2
   localparam logic REG_RADIX = 1'b0;

   typedef struct packed {
      logic load;       // take a new item
      logic div_step;   // run one divider step
      logic store;      // push the remainder digit
      logic sign_load;  // put '-' in the output register
      logic char_load;  // put the stacked digit in the output register
   } cmd_type;

   typedef struct packed {
      logic quot_zero;
      logic cnt_full;
      logic negative;
      logic last_digit;
      logic out_free;
   } status_type;

   function automatic logic [RADIX_W-1:0] eff_base(input logic [RADIX_W-1:0] radix);
      logic [RADIX_W-1:0] b;
      b = radix;
      if (radix < BASE_MIN) b = BASE_MIN;
      else if (radix > BASE_MAX) b = BASE_MAX;
      return b;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < 6'd10) c = ASCII_ZERO + CHAR_W'(d);
      else c = ASCII_A + CHAR_W'(d - 6'd10);
      return c;
   endfunction

endpackage

FILE: hdl/sirt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_ctrl
// Sequencer: accept an item, run the divider once per digit, stack digits,
// then play the sign and the digits out most significant first.
// ----------------------------------------------------------------------------
module sirt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sirt_pkg::status_type status,
   output sirt_pkg::cmd_type   cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DIV   = 6'b000010,
      ST_STORE = 6'b000100,
      ST_SIGN  = 6'b001000,
      ST_FETCH = 6'b010000,
      ST_LOAD  = 6'b100000
   } state_type;

   state_type                     state_ff, state_in;
   logic [sirt_pkg::STEP_W-1:0]   step_ff, step_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == sirt_pkg::STEP_W'(sirt_pkg::STEPS - 1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            step_in   = '0;
            if (status.quot_zero || status.cnt_full) begin
               state_in = status.negative ? ST_SIGN : ST_FETCH;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.sign_load = 1'b1;
               state_in      = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;   // stack read data lands next cycle
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.char_load = 1'b1;
               state_in      = status.last_digit ? ST_IDLE : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

FILE: hdl/sirt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_dp
// Datapath: magnitude/quotient shift register with a radix-16 restoring
// divider step, digit stack memory and the output register.
// ----------------------------------------------------------------------------
module sirt_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  sirt_pkg::cmd_type                   cmd,
   output sirt_pkg::status_type                status,
   input  logic [sirt_pkg::RADIX_W-1:0]        base,
   input  logic signed [sirt_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sirt_pkg::CHAR_W-1:0]         rsp_text_char,
   output logic                                rsp_last_char
);

   logic [sirt_pkg::MAG_W-1:0]   quot_ff, quot_in;
   logic [sirt_pkg::DIG_W-1:0]   rem_ff, rem_in;
   logic                         neg_ff, neg_in;
   logic [sirt_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [sirt_pkg::DIG_W-1:0]   stack_mem [sirt_pkg::DEPTH];
   logic [sirt_pkg::DIG_W-1:0]   rd_data_ff;
   logic [sirt_pkg::CNT_W-1:0]   rd_addr;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [sirt_pkg::CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic [sirt_pkg::MAG_W-1:0]   step_quot;
   logic [sirt_pkg::DIG_W-1:0]   step_rem;
   logic [sirt_pkg::MAG_W-1:0]   load_mag;

   // -2^62 .. -1 map to magnitudes 2^62 .. 1
   assign load_mag = req_value[sirt_pkg::VALUE_W-1]
                   ? ({1'b1, {(sirt_pkg::MAG_W-1){1'b0}}} - {1'b0, req_value})
                   : {1'b0, req_value};

   // four restoring steps; remainder stays below base
   always_comb begin
      logic [sirt_pkg::DIG_W:0]   r;
      logic [sirt_pkg::MAG_W-1:0] q;
      logic [sirt_pkg::DIG_W-1:0] rm;
      q  = quot_ff;
      rm = rem_ff;
      for (int i = 0; i < sirt_pkg::BITS_PER_STEP; i++) begin
         r = {rm, q[sirt_pkg::MAG_W-1]};
         q = {q[sirt_pkg::MAG_W-2:0], 1'b0};
         if (r >= {1'b0, base}) begin
            r    = r - {1'b0, base};
            q[0] = 1'b1;
         end
         rm = r[sirt_pkg::DIG_W-1:0];
      end
      step_quot = q;
      step_rem  = rm;
   end

   assign rd_addr = cnt_ff - 1'b1;

   always_comb begin
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      if (cmd.load) begin
         quot_in = load_mag;
         rem_in  = '0;
         neg_in  = req_value[sirt_pkg::VALUE_W-1];
         cnt_in  = '0;
      end
      if (cmd.div_step) begin
         quot_in = step_quot;
         rem_in  = step_rem;
      end
      if (cmd.store) begin
         rem_in = '0;
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.sign_load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = sirt_pkg::ASCII_MINUS;
         rsp_last_in  = 1'b0;
      end
      if (cmd.char_load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = sirt_pkg::digit_char(rd_data_ff);
         rsp_last_in  = status.last_digit;
         cnt_in       = cnt_ff - 1'b1;
      end
   end

   always_comb begin
      status.quot_zero  = (quot_ff == '0);
      status.cnt_full   = (cnt_ff == sirt_pkg::CNT_W'(sirt_pkg::DEPTH - 2));
      status.negative   = neg_ff;
      status.last_digit = (cnt_ff == sirt_pkg::CNT_W'(1));
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         stack_mem[cnt_ff] <= rem_ff;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

endmodule

FILE: hdl/signed_integer_to_radix_text.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text
// Converts a 63-bit signed integer to ASCII text in a programmable base.
// ----------------------------------------------------------------------------
// One item in, one or more characters out: '-' for a negative value, then
// the digits of the magnitude most significant first ('0'-'9', 'A'-'Z'),
// with rsp_last_char set on the final one. The base comes from the radix
// register (byte address 0, reset 16); 0 and 1 act as 2, 37..63 as 36.
// Each digit comes from one full division of the 64-bit magnitude by the
// base in the shared divider, which takes four quotient bits per cycle, and
// is then pushed on the stack. The digits are then read back from the stack
// into the output register, each through a fetch and a load state, after
// the sign for a negative value. req_stall stays high until the final
// character is in the output register, so the next item can be taken while
// that character waits.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [sirt_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sirt_pkg::CHAR_W-1:0]         rsp_text_char,
   output logic                                rsp_last_char,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [sirt_pkg::ADDR_W-1:0]         paddr,
   input  logic [sirt_pkg::DATA_W-1:0]         pwdata,
   output logic [sirt_pkg::DATA_W-1:0]         prdata,
   output logic                                pready
);

   logic [sirt_pkg::RADIX_W-1:0] radix_ff, radix_in;
   logic [sirt_pkg::RADIX_W-1:0] base;
   sirt_pkg::cmd_type            cmd;
   sirt_pkg::status_type         status;

   assign pready = 1'b1;

   always_comb begin
      radix_in = radix_ff;
      if (psel && penable && pwrite && (paddr[2] == sirt_pkg::REG_RADIX)) begin
         radix_in = pwdata[sirt_pkg::RADIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= sirt_pkg::RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   assign prdata = (paddr[2] == sirt_pkg::REG_RADIX)
                 ? {{(sirt_pkg::DATA_W-sirt_pkg::RADIX_W){1'b0}}, radix_ff}
                 : '0;

   assign base = sirt_pkg::eff_base(radix_ff);

   sirt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sirt_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .base          (base),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

FILE: tb/sv/signed_integer_to_radix_text_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_checker
// Watches the converter's ports, predicts the text of every item taken and
// compares each character that leaves the block against that prediction.
// ----------------------------------------------------------------------------
// The radix register is tracked from the APB writes seen on the bus, and APB
// reads of it are checked against the tracked value. The count of failures
// and the number of characters still owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [sirt_pkg::VALUE_W-1:0]   req_value,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [sirt_pkg::CHAR_W-1:0]    rsp_text_char,
   input  logic                           rsp_last_char,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [sirt_pkg::ADDR_W-1:0]    paddr,
   input  logic [sirt_pkg::DATA_W-1:0]    pwdata,
   input  logic [sirt_pkg::DATA_W-1:0]    prdata,
   input  logic                           pready,
   output int                             failures,
   output int                             chars_owed
);

   localparam logic [8*36-1:0] DIGIT_TABLE = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

   typedef struct packed {
      logic [sirt_pkg::CHAR_W-1:0] text_char;
      logic                        last_char;
   } text_char_type;

   text_char_type                expected_text[$];
   logic [sirt_pkg::RADIX_W-1:0] radix_shadow;

   initial begin
      failures     = 0;
      chars_owed   = 0;
      radix_shadow = sirt_pkg::RADIX_RESET;
   end

   // Queue up the characters that one value turns into.
   task automatic predict_text(input logic [sirt_pkg::VALUE_W-1:0] value);
      logic [sirt_pkg::MAG_W-1:0] mag;
      logic [sirt_pkg::MAG_W-1:0] base;
      int                         rev [0:63];
      int                         nd;
      int                         i;
      text_char_type              c;
      if (radix_shadow < 6'd2) base = 64'd2;
      else if (radix_shadow > 6'd36) base = 64'd36;
      else base = sirt_pkg::MAG_W'(radix_shadow);
      // two's complement magnitude; -2^62 stays exact in 64 bits
      if (value[sirt_pkg::VALUE_W-1]) mag = (64'd1 << 63) - {1'b0, value};
      else mag = {1'b0, value};
      nd = 0;
      do begin
         rev[nd] = int'(mag % base);
         nd++;
         mag = mag / base;
      end while (mag != 0 && nd < 64);
      if (value[sirt_pkg::VALUE_W-1]) begin
         c.text_char = sirt_pkg::ASCII_MINUS;
         c.last_char = 1'b0;
         expected_text.push_back(c);
      end
      for (i = nd - 1; i >= 0; i--) begin
         c.text_char = sirt_pkg::CHAR_W'(DIGIT_TABLE[8*(35-rev[i]) +: 8]);
         c.last_char = (i == 0);
         expected_text.push_back(c);
      end
   endtask

   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         expected_text.delete();
         radix_shadow = sirt_pkg::RADIX_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               $error("unexpected char %0h last %0b", rsp_text_char, rsp_last_char);
               failures++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_text_char !== want.text_char) begin
                  $error("text_char expected %0h actual %0h", want.text_char, rsp_text_char);
                  failures++;
               end
               if (rsp_last_char !== want.last_char) begin
                  $error("last_char expected %0b actual %0b", want.last_char, rsp_last_char);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) predict_text(req_value);
         if (psel && penable && pready && paddr[2] == sirt_pkg::REG_RADIX) begin
            if (pwrite) begin
               radix_shadow = pwdata[sirt_pkg::RADIX_W-1:0];
            end else if (prdata[sirt_pkg::RADIX_W-1:0] !== radix_shadow) begin
               $error("radix expected %0d actual %0d", radix_shadow,
                      prdata[sirt_pkg::RADIX_W-1:0]);
               failures++;
            end
         end
      end
      chars_owed = expected_text.size();
   end

endmodule

FILE: tb/sv/signed_integer_to_radix_text_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_tb
// Stimulus and verdict for the signed integer to radix text converter.
// ----------------------------------------------------------------------------
// Directed values at the edges of the range across the extreme bases, then
// random values of random length under several radix settings and several
// idle/stall mixes, one of them with a long output hold-off. Checking is
// done by the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text_tb;

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int LONG_HOLD   = 2000;
   localparam int SEG_ITEMS   = 30;

   localparam logic [sirt_pkg::ADDR_W-1:0] RADIX_ADDR  = 3'd0;
   localparam logic [sirt_pkg::ADDR_W-1:0] UNUSED_ADDR = 3'd4;

   localparam logic [sirt_pkg::VALUE_W-1:0] VALUE_MAX = {1'b0, {(sirt_pkg::VALUE_W-1){1'b1}}};
   localparam logic [sirt_pkg::VALUE_W-1:0] VALUE_MIN = {1'b1, {(sirt_pkg::VALUE_W-1){1'b0}}};

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic signed [sirt_pkg::VALUE_W-1:0] req_value;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic [sirt_pkg::CHAR_W-1:0]         rsp_text_char;
   logic                                rsp_last_char;
   logic                                psel;
   logic                                penable;
   logic                                pwrite;
   logic [sirt_pkg::ADDR_W-1:0]         paddr;
   logic [sirt_pkg::DATA_W-1:0]         pwdata;
   logic [sirt_pkg::DATA_W-1:0]         prdata;
   logic                                pready;

   int failures;
   int chars_owed;
   int idle_pct;
   int stall_pct;
   int hold_left;
   int cycle_count;
   bit pressure_on;
   bit pressure_done;

   signed_integer_to_radix_text dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_text_char(rsp_text_char), .rsp_last_char(rsp_last_char),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   signed_integer_to_radix_text_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_text_char(rsp_text_char), .rsp_last_char(rsp_last_char),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .failures(failures), .chars_owed(chars_owed)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      idle_pct      = 0;
      stall_pct     = 0;
      hold_left     = 0;
      cycle_count   = 0;
      pressure_on   = 1'b0;
      pressure_done = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("signed_integer_to_radix_text_tb: FAIL");
         $finish;
      end
   end

   // Output side: random stall, plus one long hold-off while the sender
   // keeps pushing, so the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (pressure_on && !pressure_done) begin
         hold_left     = LONG_HOLD;
         pressure_done = 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic send_value(input logic [sirt_pkg::VALUE_W-1:0] v);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_value <= sirt_pkg::VALUE_W'({$urandom, $urandom});
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (chars_owed != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [sirt_pkg::ADDR_W-1:0] addr,
                            input logic [sirt_pkg::DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_radix();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= RADIX_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Radix change; upper data bits are junk and must be dropped.
   task automatic set_radix(input logic [sirt_pkg::RADIX_W-1:0] r);
      logic [sirt_pkg::DATA_W-1:0] data;
      wait_idle();
      data = $urandom;
      data[sirt_pkg::RADIX_W-1:0] = r;
      csr_write(RADIX_ADDR, data);
      csr_read_radix();
   endtask

   // Mostly values of random bit length; some full width and edges.
   function automatic logic [sirt_pkg::VALUE_W-1:0] rand_value();
      logic [63:0]                  r;
      logic [sirt_pkg::VALUE_W-1:0] v;
      int                           len;
      int                           kind;
      r    = {$urandom, $urandom};
      kind = $urandom_range(0, 9);
      if (kind == 0) return r[sirt_pkg::VALUE_W-1:0];
      if (kind == 1) begin
         case ($urandom_range(0, 3))
            0: v = VALUE_MIN;
            1: v = VALUE_MAX;
            2: v = '0;
            default: v = '1;
         endcase
         return v;
      end
      len = $urandom_range(0, 62);
      r   = r & ((64'd1 << len) - 64'd1);
      v   = r[sirt_pkg::VALUE_W-1:0];
      if ($urandom_range(0, 1) == 1) v = -v;
      return v;
   endfunction

   initial begin
      int phase;
      int seg;
      int n;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_value <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset base sixteen first
      send_value('0);
      send_value(63'd1);
      send_value('1);
      send_value(VALUE_MAX);
      send_value(VALUE_MIN);
      send_value(63'd15);
      send_value(63'd16);
      send_value(-63'sd16);
      // base two: the most negative value is the longest text
      set_radix(6'd2);
      send_value(VALUE_MIN);
      send_value(VALUE_MAX);
      send_value('0);
      send_value('1);
      set_radix(6'd36);
      send_value(63'd35);
      send_value(-63'sd36);
      send_value(VALUE_MAX);
      send_value(VALUE_MIN);
      // out-of-range register values clamp to 2 and 36
      set_radix(6'd0);
      send_value(63'd5);
      set_radix(6'd1);
      send_value(-63'sd6);
      set_radix(6'd37);
      send_value(63'd35);
      set_radix(6'd63);
      send_value(VALUE_MAX);
      set_radix(6'd10);
      send_value(63'd1234567890);
      send_value(-63'sd9);
      // write to an unmapped register must leave the radix alone
      wait_idle();
      csr_write(UNUSED_ADDR, 32'hFFFF_FFC2);
      csr_read_radix();
      send_value(63'd255);

      for (phase = 0; phase < 4; phase++) begin
         wait_idle();
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 81; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 81; end
            default: begin idle_pct = 9; stall_pct = 9; end
         endcase
         for (seg = 0; seg < 3; seg++) begin
            set_radix(6'($urandom_range(0, 63)));
            if ($urandom_range(0, 2) == 0) begin
               wait_idle();
               csr_write(UNUSED_ADDR, $urandom);
            end
            if (phase == 0 && seg == 0) pressure_on = 1'b1;
            for (n = 0; n < SEG_ITEMS; n++) send_value(rand_value());
         end
      end

      wait_idle();
      repeat (50) @(posedge clock);
      if (failures == 0 && chars_owed == 0) begin
         $display("signed_integer_to_radix_text_tb: PASS");
      end else begin
         $display("signed_integer_to_radix_text_tb: FAIL");
      end
      $finish;
   end

endmodule
